@@ rtl/sed_pkg.sv @@
`default_nettype none

package sed_pkg;

    localparam int WIDTH_DEF = 32;

    typedef struct packed {
        logic start;
    } t_core_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_sts;

endpackage

`default_nettype wire

@@ rtl/sed_core.sv @@
`default_nettype none

module sed_core #(
    parameter int WIDTH = sed_pkg::WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sed_pkg::t_core_ctl i_ctl,
    input  wire logic [WIDTH-1:0]  i_num,
    input  wire logic [WIDTH-1:0]  i_den,
    output sed_pkg::t_core_sts     o_sts,
    output logic      [WIDTH-1:0]  o_quo,
    output logic      [WIDTH-1:0]  o_rem
);
    import sed_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);

    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_den;
    logic [WIDTH:0]   w_trial;

    assign w_trial = {r_rem, r_quo[WIDTH-1]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(WIDTH);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[WIDTH-2:0], ~w_trial[WIDTH]};
            if (!w_trial[WIDTH]) begin
                r_rem <= w_trial[WIDTH-1:0];
            end else begin
                r_rem <= {r_rem[WIDTH-2:0], r_quo[WIDTH-1]};
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_busy && (r_cnt == CW'(1));
    assign o_quo      = r_quo;
    assign o_rem      = r_rem;

endmodule

`default_nettype wire

@@ rtl/signed_euclidean_divider.sv @@
// Signed Euclidean divider.
// Input channel: i_in_valid / o_in_stall carry one beat of i_dividend and
// i_divisor (WIDTH-bit two's complement). Output channel: o_out_valid /
// i_out_stall carry o_quotient (WIDTH+1 bits, signed), o_remainder
// (WIDTH-1 bits, 0 <= r < |divisor|) and o_divide_by_zero. A zero divisor
// gives zero quotient and remainder with the flag set.
// One item is in flight at a time. The magnitude divider retires one
// quotient bit per cycle in shift-subtract steps; sign correction (S_FIX)
// and output load (S_OUT) follow. A new beat is taken only once the
// previous result has been loaded into the output register.
// The output register lets the next beat be accepted while a result still
// waits; if the receiver stalls long enough, the finished item is held
// until the output register frees up, and o_in_stall stays high meanwhile.
// Synchronous active-low reset empties the block and drops any item.
`default_nettype none

module signed_euclidean_divider #(
    parameter int WIDTH = sed_pkg::WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [WIDTH-1:0]  i_dividend,
    input  wire logic [WIDTH-1:0]  i_divisor,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [WIDTH:0]    o_quotient,
    output logic      [WIDTH-2:0]  o_remainder,
    output logic                   o_divide_by_zero
);
    import sed_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_FIX  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic             r_nneg;
    logic             r_qneg;
    logic             r_dz;
    logic [WIDTH-1:0] r_b;
    logic [WIDTH:0]   r_q;
    logic [WIDTH-1:0] r_r;
    logic             r_out_valid;

    logic             w_accept;
    logic             w_load;
    logic             w_inc;
    logic [WIDTH-1:0] w_amag;
    logic [WIDTH-1:0] w_bmag;
    logic [WIDTH-1:0] w_quo;
    logic [WIDTH-1:0] w_rem;
    t_core_ctl        w_ctl;
    t_core_sts        w_sts;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_load     = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);
    assign w_inc      = r_nneg && (w_rem != '0);

    assign w_amag = i_dividend[WIDTH-1] ? (~i_dividend + WIDTH'(1)) : i_dividend;
    assign w_bmag = i_divisor[WIDTH-1]  ? (~i_divisor + WIDTH'(1))  : i_divisor;

    assign w_ctl.start = w_accept;

    sed_core #(
        .WIDTH(WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_num   (w_amag),
        .i_den   (w_bmag),
        .o_sts   (w_sts),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_sts.done) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_nneg <= i_dividend[WIDTH-1];
            r_qneg <= i_dividend[WIDTH-1] ^ i_divisor[WIDTH-1];
            r_dz   <= (i_divisor == '0);
            r_b    <= w_bmag;
        end
        if (r_state == S_FIX) begin
            r_q <= {1'b0, w_quo} + {{WIDTH{1'b0}}, w_inc};
            r_r <= w_inc ? (r_b - w_rem) : w_rem;
        end
        if (w_load) begin
            o_quotient       <= r_dz ? '0 : (r_qneg ? (~r_q + (WIDTH+1)'(1)) : r_q);
            o_remainder      <= r_dz ? '0 : r_r[WIDTH-2:0];
            o_divide_by_zero <= r_dz;
        end
    end

    assign o_out_valid = r_out_valid;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_DIV) && w_sts.busy)
        else $error("accepted beat did not start the divider");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DIV) |-> !w_sts.done)
        else $error("divider finished outside the divide phase");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIX) && !r_dz |-> (w_rem < r_b))
        else $error("magnitude remainder not below divisor");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_divide_by_zero |-> (o_quotient == '0) && (o_remainder == '0))
        else $error("divide by zero result not cleared");

endmodule

`default_nettype wire
